@@ rtl/core/mss_pkg.sv @@
// Shared types and constants for the maximum subarray sum block.
package mss_pkg;

    localparam int unsigned MAX_LEN_DEF = 1024;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned BEST_W      = 41;

    localparam logic [BEST_W-1:0] BEST_SUM_MAX = '1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Sequencer commands to the scan unit.
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

endpackage

@@ rtl/core/max_subarray_sum_with_ends.sv @@
// Maximum contiguous run sum over a loaded sequence, with the run's end values.
// Throughput: one word per cycle while loading; the word marked last starts a
// scan of n stored words, one per cycle through a shared add/compare unit, and
// the result is valid once the last stored word has passed that unit (n <= MAX_LEN).
// No word is taken from the scan start until the result is taken.
// Reset (i_rst_n low, synchronous) empties the sequence; store contents stay.
module max_subarray_sum_with_ends #(
    parameter int unsigned MAX_LEN = mss_pkg::MAX_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [mss_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_is_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mss_pkg::BEST_W-1:0]         o_best_sum,
    output logic signed [mss_pkg::VALUE_W-1:0] o_start_value,
    output logic signed [mss_pkg::VALUE_W-1:0] o_end_value
);
    import mss_pkg::*;

    localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned SUM_W  = VALUE_W + CNT_W;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic [VALUE_W-1:0] rdata;
    t_scan_ctl          scan_ctl;
    logic [ADDR_W-1:0]  scan_k;

    mss_ctrl #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_ctl       (scan_ctl),
        .o_k         (scan_k)
    );

    mss_store #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (unsigned'(i_value)),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mss_scan #(
        .ADDR_W (ADDR_W),
        .SUM_W  (SUM_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_value       (signed'(rdata)),
        .i_k           (scan_k),
        .o_best_sum    (o_best_sum),
        .o_start_value (o_start_value),
        .o_end_value   (o_end_value)
    );

endmodule

@@ rtl/core/mss_store.sv @@
// Element store: one write port, one registered read port.
module mss_store #(
    parameter int unsigned MAX_LEN = 1024,
    parameter int unsigned ADDR_W  = 10
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [mss_pkg::VALUE_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [mss_pkg::VALUE_W-1:0]  o_rdata
);
    import mss_pkg::*;

    logic [VALUE_W-1:0] r_mem [MAX_LEN];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mss_scan.sv @@
// Scan unit: one shared add/compare step per stored word, tracks best run.
module mss_scan #(
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned SUM_W  = 43
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mss_pkg::t_scan_ctl                 i_ctl,
    input  logic signed [mss_pkg::VALUE_W-1:0] i_value,
    input  logic [ADDR_W-1:0]                  i_k,
    output logic [mss_pkg::BEST_W-1:0]         o_best_sum,
    output logic signed [mss_pkg::VALUE_W-1:0] o_start_value,
    output logic signed [mss_pkg::VALUE_W-1:0] o_end_value
);
    import mss_pkg::*;

    localparam int unsigned EXT_W = (SUM_W > BEST_W + 1) ? SUM_W : BEST_W + 1;

    logic                      r_found;
    logic                      r_zero_seen;
    logic signed [SUM_W-1:0]   r_cur;
    logic [ADDR_W-1:0]         r_st_idx;
    logic signed [VALUE_W-1:0] r_st_val;
    logic signed [SUM_W-1:0]   r_best;
    logic [ADDR_W-1:0]         r_best_idx;
    logic signed [VALUE_W-1:0] r_best_sv;
    logic signed [VALUE_W-1:0] r_best_ev;
    logic signed [VALUE_W-1:0] r_first_val;
    logic signed [VALUE_W-1:0] r_last_val;

    logic                      restart;
    logic signed [SUM_W-1:0]   run;
    logic [ADDR_W-1:0]         st_idx;
    logic signed [VALUE_W-1:0] st_val;
    logic                      upd;
    logic [EXT_W-1:0]          best_ext;

    // A negative running sum means the run restarts at this word; zero keeps
    // the earlier start so ties go to the smaller start.
    always_comb begin
        restart = r_cur[SUM_W-1];
        run     = (restart ? SUM_W'(0) : r_cur) + SUM_W'(i_value);
        st_idx  = restart ? i_k : r_st_idx;
        st_val  = restart ? i_value : r_st_val;
        upd     = (run > r_best) ||
                  (r_found && (run == r_best) && (st_idx < r_best_idx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_zero_seen <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found     <= 1'b0;
            r_zero_seen <= 1'b0;
        end else if (i_ctl.step) begin
            if (upd) begin
                r_found <= 1'b1;
            end
            if (i_value == '0) begin
                r_zero_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_cur  <= '1;
            r_best <= '0;
        end else if (i_ctl.step) begin
            r_cur      <= run;
            r_st_idx   <= st_idx;
            r_st_val   <= st_val;
            r_last_val <= i_value;
            if (i_k == '0) begin
                r_first_val <= i_value;
            end
            if (upd) begin
                r_best     <= run;
                r_best_idx <= st_idx;
                r_best_sv  <= st_val;
                r_best_ev  <= i_value;
            end
        end
    end

    // Best is never negative, so zero-extend and clamp to the output width.
    always_comb begin
        best_ext = EXT_W'(unsigned'(r_best));
        if (best_ext > EXT_W'(BEST_SUM_MAX)) begin
            o_best_sum = BEST_SUM_MAX;
        end else begin
            o_best_sum = best_ext[BEST_W-1:0];
        end
        if (r_found) begin
            o_start_value = r_best_sv;
            o_end_value   = r_best_ev;
        end else if (r_zero_seen) begin
            o_start_value = '0;
            o_end_value   = '0;
        end else begin
            o_start_value = r_first_val;
            o_end_value   = r_last_val;
        end
    end

`ifndef SYNTHESIS
    a_found_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (!r_best[SUM_W-1] && (r_best != '0)))
        else $error("best run flagged but sum not positive");

    a_ctl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_ctl.clear, i_ctl.step}))
        else $error("scan clear and step in the same cycle");
`endif

endmodule

@@ rtl/core/mss_ctrl.sv @@
// Sequencer: loads words into the store, then walks it through the scan unit.
module mss_ctrl #(
    parameter int unsigned MAX_LEN = 1024,
    parameter int unsigned ADDR_W  = 10,
    parameter int unsigned CNT_W   = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_is_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic                o_re,
    output logic [ADDR_W-1:0]   o_raddr,
    output mss_pkg::t_scan_ctl  o_ctl,
    output logic [ADDR_W-1:0]   o_k
);
    import mss_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   n_rd_idx;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic [ADDR_W-1:0]  r_rd_k;
    logic               room;
    logic               issue;
    logic               clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_we        = 1'b0;
        o_re        = 1'b0;
        clear       = 1'b0;
        room        = r_count < CNT_W'(MAX_LEN);
        issue       = r_rd_idx != r_count;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // Drop words once the store is full.
                    if (room) begin
                        o_we    = 1'b1;
                        n_count = CNT_W'(r_count + CNT_W'(1));
                    end
                    if (i_is_last) begin
                        n_state  = ST_SCAN;
                        n_rd_idx = '0;
                        clear    = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    o_re     = 1'b1;
                    n_rd_idx = CNT_W'(r_rd_idx + CNT_W'(1));
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= o_re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= CNT_W'(r_rd_idx + CNT_W'(1)) == r_count;
        r_rd_k    <= r_rd_idx[ADDR_W-1:0];
    end

    assign o_waddr   = r_count[ADDR_W-1:0];
    assign o_raddr   = r_rd_idx[ADDR_W-1:0];
    assign o_k       = r_rd_k;
    assign o_ctl     = '{clear: clear, step: r_rd_vld};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("word count beyond store depth");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_idx <= r_count))
        else $error("scan read index ran past word count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_rd_vld && !o_re))
        else $error("store read active while result is held");
`endif

endmodule
